// ===== rtl/scrf_pkg.sv =====
package scrf_pkg;

    localparam int unsigned CFG_DATA_W  = 27;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned RA_CFG_W    = 27;
    localparam int unsigned DEC_CFG_W   = 26;
    localparam int unsigned MAG_W       = 8;
    localparam int unsigned INDEX_W     = 20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_MAG,
        CFG_RA_LOW,
        CFG_RA_HIGH,
        CFG_DEC_LOW,
        CFG_DEC_HIGH,
        CFG_EXCLUDE_GSC
    } cfg_index_t;

    typedef enum logic [2:0] {
        REASON_OK,
        REASON_GSC,
        REASON_POOR_MAG,
        REASON_POOR_COLOUR,
        REASON_WINDOW
    } reason_t;

    localparam logic [MAG_W-1:0]     MAX_MAG_RESET  = 8'd255;
    localparam logic [RA_CFG_W-1:0]  RA_LOW_RESET   = 27'd0;
    localparam logic [RA_CFG_W-1:0]  RA_HIGH_RESET  = 27'd129600000;
    localparam logic [DEC_CFG_W-1:0] DEC_LOW_RESET  = 26'd0;
    localparam logic [DEC_CFG_W-1:0] DEC_HIGH_RESET = 26'd64800000;

    localparam logic [30:0] MAG_LIMIT_WORD = 31'd1000000000;
    localparam logic [9:0]  POOR_COLOUR    = 10'd250;
    localparam logic [9:0]  DIGIT_BASE     = 10'd1000;

    // floor(x / 1000) as (x * RECIP) >> SHIFT, exact over the value ranges used
    localparam logic [30:0] RECIP_HI       = 31'd1099511628;
    localparam int unsigned RECIP_HI_SHIFT = 40;
    localparam logic [20:0] RECIP_LO       = 21'd1073742;
    localparam int unsigned RECIP_LO_SHIFT = 30;

    typedef struct packed {
        logic [31:0] ra_word;
        logic [31:0] dec_word;
        logic [31:0] mag_word;
        logic        new_query;
    } item_t;

    typedef struct packed {
        logic               accepted;
        logic               past_end;
        logic [2:0]         reject_reason;
        logic [31:0]        ra_raw;
        logic [31:0]        dec_raw;
        logic [MAG_W-1:0]   mag_tenths;
        logic [INDEX_W-1:0] star_index;
    } result_t;

    typedef struct packed {
        logic [MAG_W-1:0]     max_mag_tenths;
        logic [RA_CFG_W-1:0]  ra_low;
        logic [RA_CFG_W-1:0]  ra_high;
        logic [DEC_CFG_W-1:0] dec_low;
        logic [DEC_CFG_W-1:0] dec_high;
        logic                 exclude_gsc;
    } cfg_t;

    typedef struct packed {
        logic [31:0]      ra_raw;
        logic [31:0]      dec_raw;
        logic             past_end;
        reason_t          reason;
        logic [MAG_W-1:0] mag_tenths;
        logic             new_query;
    } class_t;

endpackage

// ===== rtl/scrf_front.sv =====
module scrf_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  scrf_pkg::cfg_t    cfg,
    input  scrf_pkg::item_t   item,
    input  logic              take,
    output logic              wr_en,
    output scrf_pkg::class_t  wr_data,
    output logic [1:0]        inflight
);

    logic [30:0] mag31;
    logic [61:0] prod_hi;
    logic [21:0] q1;
    logic        ra_in;
    logic        dec_in;
    logic        past_end;

    logic        s1_valid_reg;
    logic [31:0] s1_ra_reg;
    logic [31:0] s1_dec_reg;
    logic        s1_nq_reg;
    logic        s1_gsc_reg;
    logic        s1_big_reg;
    logic [30:0] s1_mag_reg;
    logic [21:0] s1_q1_reg;
    logic        s1_ra_in_reg;
    logic        s1_dec_in_reg;
    logic        s1_past_reg;

    logic [31:0] q1k;
    logic [31:0] red_w;
    logic [42:0] prod_lo;

    logic        s2_valid_reg;
    logic [31:0] s2_ra_reg;
    logic [31:0] s2_dec_reg;
    logic        s2_nq_reg;
    logic        s2_gsc_reg;
    logic        s2_big_reg;
    logic [9:0]  s2_red_reg;
    logic [21:0] s2_q1_reg;
    logic [12:0] s2_q2_reg;
    logic        s2_ra_in_reg;
    logic        s2_dec_in_reg;
    logic        s2_past_reg;

    logic [21:0] q2k;
    logic [21:0] blue_w;
    logic [9:0]  blue;
    logic [9:0]  tenths;
    scrf_pkg::reason_t reason;

    // stage 1: flag handling, range checks, first reciprocal multiply
    assign mag31    = item.mag_word[30:0];
    assign prod_hi  = 62'(mag31) * 62'(scrf_pkg::RECIP_HI);
    assign q1       = prod_hi[scrf_pkg::RECIP_HI_SHIFT +: 22];
    assign ra_in    = (item.ra_word >= 32'(cfg.ra_low)) && (item.ra_word <= 32'(cfg.ra_high));
    assign dec_in   = (item.dec_word >= 32'(cfg.dec_low))
                   && (item.dec_word <= 32'(cfg.dec_high));
    assign past_end = item.ra_word > 32'(cfg.ra_high);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ra_reg     <= item.ra_word;
        s1_dec_reg    <= item.dec_word;
        s1_nq_reg     <= item.new_query;
        s1_gsc_reg    <= item.mag_word[31] & cfg.exclude_gsc;
        s1_big_reg    <= mag31 >= scrf_pkg::MAG_LIMIT_WORD;
        s1_mag_reg    <= mag31;
        s1_q1_reg     <= q1;
        s1_ra_in_reg  <= ra_in;
        s1_dec_in_reg <= dec_in;
        s1_past_reg   <= past_end;
    end

    // stage 2: red digit group, second reciprocal multiply
    assign q1k     = 32'(s1_q1_reg) * 32'(scrf_pkg::DIGIT_BASE);
    assign red_w   = 32'(s1_mag_reg) - q1k;
    assign prod_lo = 43'(s1_q1_reg) * 43'(scrf_pkg::RECIP_LO);

    always_ff @(posedge clk)
    begin
        s2_ra_reg     <= s1_ra_reg;
        s2_dec_reg    <= s1_dec_reg;
        s2_nq_reg     <= s1_nq_reg;
        s2_gsc_reg    <= s1_gsc_reg;
        s2_big_reg    <= s1_big_reg;
        s2_red_reg    <= red_w[9:0];
        s2_q1_reg     <= s1_q1_reg;
        s2_q2_reg     <= prod_lo[scrf_pkg::RECIP_LO_SHIFT +: 13];
        s2_ra_in_reg  <= s1_ra_in_reg;
        s2_dec_in_reg <= s1_dec_in_reg;
        s2_past_reg   <= s1_past_reg;
    end

    // classify and hand over to the queue
    assign q2k    = 22'(s2_q2_reg) * 22'(scrf_pkg::DIGIT_BASE);
    assign blue_w = s2_q1_reg - q2k;
    assign blue   = blue_w[9:0];

    always_comb
    begin
        reason = scrf_pkg::REASON_OK;
        tenths = 10'd0;
        if (s2_gsc_reg)
        begin
            reason = scrf_pkg::REASON_GSC;
        end
        else if (s2_big_reg)
        begin
            reason = scrf_pkg::REASON_POOR_MAG;
        end
        else if (s2_red_reg > scrf_pkg::POOR_COLOUR)
        begin
            if (blue > scrf_pkg::POOR_COLOUR)
            begin
                reason = scrf_pkg::REASON_POOR_COLOUR;
            end
            else
            begin
                tenths = blue;
            end
        end
        else
        begin
            tenths = s2_red_reg;
        end

        if (reason == scrf_pkg::REASON_OK)
        begin
            if (!(tenths <= 10'(cfg.max_mag_tenths) && s2_ra_in_reg && s2_dec_in_reg))
            begin
                reason = scrf_pkg::REASON_WINDOW;
            end
        end
    end

    assign wr_en              = s2_valid_reg;
    assign wr_data.ra_raw     = s2_ra_reg;
    assign wr_data.dec_raw    = s2_dec_reg;
    assign wr_data.past_end   = s2_past_reg;
    assign wr_data.reason     = reason;
    assign wr_data.mag_tenths = tenths[scrf_pkg::MAG_W-1:0];
    assign wr_data.new_query  = s2_nq_reg;
    assign inflight           = 2'(s1_valid_reg) + 2'(s2_valid_reg);

endmodule

// ===== rtl/scrf_queue.sv =====
module scrf_queue
#(
    parameter int unsigned DEPTH = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  scrf_pkg::class_t             wr_data,
    input  logic                         rd_en,
    output scrf_pkg::class_t             rd_data,
    output logic                         not_empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH+1);

    scrf_pkg::class_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

endmodule

// ===== rtl/scrf_back.sv =====
module scrf_back
#(
    parameter int unsigned COUNT_BITS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               has_item,
    input  scrf_pkg::class_t   head,
    output logic               take,
    input  logic               pop,
    output logic               empty,
    output scrf_pkg::result_t  result
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] base;
    logic [31:0]           index_ext;
    logic                  ok;
    logic                  out_valid_reg;
    scrf_pkg::result_t     result_reg;
    scrf_pkg::result_t     result_next;

    assign take = has_item && (!out_valid_reg || pop);
    assign ok   = head.reason == scrf_pkg::REASON_OK;
    assign base = head.new_query ? '0 : count_reg;

    always_comb
    begin
        count_next = base;
        index_ext  = 32'd0;
        if (ok)
        begin
            count_next = base + 1'b1;
            index_ext  = 32'(base);
        end
        result_next.accepted      = ok;
        result_next.past_end      = head.past_end;
        result_next.reject_reason = head.reason;
        result_next.ra_raw        = head.ra_raw;
        result_next.dec_raw       = head.dec_raw;
        result_next.mag_tenths    = head.mag_tenths;
        result_next.star_index    = index_ext[scrf_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_accept_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.accepted
            |-> result_reg.reject_reason == scrf_pkg::REASON_OK)
        else $error("accepted result with nonzero reject reason");

    a_reject_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.accepted |-> result_reg.star_index == '0)
        else $error("rejected result carries a star index");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        take && ok && !head.new_query
            |=> count_reg == COUNT_BITS'($past(count_reg) + 1'b1))
        else $error("accepted count did not advance by one");
`endif

endmodule

// ===== rtl/star_catalog_record_filter.sv =====
// Star catalog record filter: takes one catalog record (RA, dec+90deg and packed
// magnitude words) per request and returns one result per record, in order, with
// accept flag, reject reason, end-of-swath flag, chosen magnitude and star index.
// Sustained rate is one record per clock while pop is held high. A record goes
// through two front stages (reciprocal multiplies for the decimal colour split),
// the queue write and the output register. full rises once the queue plus records
// still in the front stages reach QUEUE_DEPTH, so when pop is held high the block
// never stalls. The user must write registers through cfg_we/cfg_index/cfg_data
// only while no record is in flight (unchecked); indexes above 5 are ignored.
module star_catalog_record_filter
#(
    parameter int unsigned COUNT_BITS  = 20,
    parameter int unsigned QUEUE_DEPTH = 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  scrf_pkg::item_t                      item,
    output logic                                 empty,
    input  logic                                 pop,
    output scrf_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [scrf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [scrf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

    scrf_pkg::cfg_t     cfg_reg;
    scrf_pkg::class_t   wr_data;
    scrf_pkg::class_t   head;
    logic               take_in;
    logic               wr_en;
    logic               rd_en;
    logic               has_item;
    logic [1:0]         inflight;
    logic [CNT_W-1:0]   q_count;
    logic [CNT_W:0]     occupancy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_mag_tenths <= scrf_pkg::MAX_MAG_RESET;
            cfg_reg.ra_low         <= scrf_pkg::RA_LOW_RESET;
            cfg_reg.ra_high        <= scrf_pkg::RA_HIGH_RESET;
            cfg_reg.dec_low        <= scrf_pkg::DEC_LOW_RESET;
            cfg_reg.dec_high       <= scrf_pkg::DEC_HIGH_RESET;
            cfg_reg.exclude_gsc    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scrf_pkg::CFG_MAX_MAG:
                    cfg_reg.max_mag_tenths <= cfg_data[scrf_pkg::MAG_W-1:0];
                scrf_pkg::CFG_RA_LOW:
                    cfg_reg.ra_low <= cfg_data[scrf_pkg::RA_CFG_W-1:0];
                scrf_pkg::CFG_RA_HIGH:
                    cfg_reg.ra_high <= cfg_data[scrf_pkg::RA_CFG_W-1:0];
                scrf_pkg::CFG_DEC_LOW:
                    cfg_reg.dec_low <= cfg_data[scrf_pkg::DEC_CFG_W-1:0];
                scrf_pkg::CFG_DEC_HIGH:
                    cfg_reg.dec_high <= cfg_data[scrf_pkg::DEC_CFG_W-1:0];
                scrf_pkg::CFG_EXCLUDE_GSC:
                    cfg_reg.exclude_gsc <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    assign occupancy = (CNT_W+1)'(q_count) + (CNT_W+1)'(inflight);
    assign full      = occupancy >= (CNT_W+1)'(QUEUE_DEPTH);
    assign take_in   = push && !full;

    scrf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .item     (item),
        .take     (take_in),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .inflight (inflight)
    );

    scrf_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_data   (head),
        .not_empty (has_item),
        .count     (q_count)
    );

    scrf_back
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .has_item (has_item),
        .head     (head),
        .take     (rd_en),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule
